### design/light_sensor_auto_gain_ranging_core_macros.svh
// Assertion macros for the light sensor auto gain ranging core.
`ifndef LIGHT_SENSOR_AUTO_GAIN_RANGING_CORE_MACROS_SVH
`define LIGHT_SENSOR_AUTO_GAIN_RANGING_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSAGR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsagr: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LSAGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsagr: check failed");

`endif

### design/lsagr_pkg.sv
// Types and constants shared by the auto gain ranging modules.
package lsagr_pkg;

  localparam int CountW = 16;
  localparam int GainW  = 2;
  localparam int TimeW  = 3;
  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_SEARCH   = 2'd0,
    MODE_REC_UP   = 2'd1,
    MODE_REC_DOWN = 2'd2,
    MODE_DONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_DOWN = 2'd0,
    DIR_UP   = 2'd1,
    DIR_NONE = 2'd2
  } dir_t;

  localparam logic FuncRestart = 1'b0;
  localparam logic FuncMeasure = 1'b1;

  localparam logic [GainW-1:0]  StartGain = 2'h0;
  localparam logic [TimeW-1:0]  StartTime = 3'h2;
  localparam logic [CountW-1:0] CountZero = 16'h0000;
  localparam logic [CountW-1:0] CountFull = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] CfgLowThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHighThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainFloor     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainCeiling   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeFloor     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTimeCeiling   = 3'd5;

  localparam logic [CountW-1:0] RstLowThreshold  = 16'd1000;
  localparam logic [CountW-1:0] RstHighThreshold = 16'd50000;
  localparam logic [GainW-1:0]  RstGainFloor     = 2'd0;
  localparam logic [GainW-1:0]  RstGainCeiling   = 2'd3;
  localparam logic [TimeW-1:0]  RstTimeFloor     = 3'd0;
  localparam logic [TimeW-1:0]  RstTimeCeiling   = 3'd5;

  typedef struct packed {
    logic [CountW-1:0] low;
    logic [CountW-1:0] high;
    logic [GainW-1:0]  gain_floor;
    logic [GainW-1:0]  gain_ceiling;
    logic [TimeW-1:0]  time_floor;
    logic [TimeW-1:0]  time_ceiling;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    dir_t              dir;
    logic [GainW-1:0]  gain;
    logic [TimeW-1:0]  time_c;
  } state_t;

  typedef struct packed {
    logic              func;
    logic [CountW-1:0] vis;
    logic [CountW-1:0] ir;
  } item_t;

  typedef struct packed {
    logic [GainW-1:0]  gain_code;
    logic [TimeW-1:0]  time_code;
    logic              done_res;
    logic [CountW-1:0] vis_out;
    logic [CountW-1:0] ir_out;
  } res_t;

endpackage

### design/light_sensor_auto_gain_ranging_core.sv
// Light sensor auto gain ranging: top level with item, result and config registers.
// Path: an accepted item is held in the input register, then moves to the result register, raising out_valid.
// Throughput: one item per cycle while out_stall is low; the ranging state updates in one pass per item.
// in_stall rises only while the input register holds an item the result reg can't take.
// Reset (rst_n low, synchronous): search mode, no direction, gain 0, time 2,
// registers at their defaults, both pipeline registers empty.
`include "light_sensor_auto_gain_ranging_core_macros.svh"

module light_sensor_auto_gain_ranging_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [lsagr_pkg::CountW-1:0]  in_vis,
  input  logic [lsagr_pkg::CountW-1:0]  in_ir,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsagr_pkg::GainW-1:0]   out_gain_code,
  output logic [lsagr_pkg::TimeW-1:0]   out_time_code,
  output logic                          out_done_res,
  output logic [lsagr_pkg::CountW-1:0]  out_vis_out,
  output logic [lsagr_pkg::CountW-1:0]  out_ir_out,
  input  logic                          cfg_wr_en,
  input  logic [lsagr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lsagr_pkg::CountW-1:0]  cfg_wdata
);
  import lsagr_pkg::*;

  cfg_t   cfg_r;
  state_t st_r;
  state_t st_nxt;
  item_t  item_r;
  res_t   res_nxt;
  res_t   res_r;
  logic   in_valid_r;
  logic   out_valid_r;
  logic   fire;
  logic   in_take;

  // result register can take the held item
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low          <= RstLowThreshold;
      cfg_r.high         <= RstHighThreshold;
      cfg_r.gain_floor   <= RstGainFloor;
      cfg_r.gain_ceiling <= RstGainCeiling;
      cfg_r.time_floor   <= RstTimeFloor;
      cfg_r.time_ceiling <= RstTimeCeiling;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgLowThreshold:  cfg_r.low          <= cfg_wdata;
        CfgHighThreshold: cfg_r.high         <= cfg_wdata;
        CfgGainFloor:     cfg_r.gain_floor   <= cfg_wdata[GainW-1:0];
        CfgGainCeiling:   cfg_r.gain_ceiling <= cfg_wdata[GainW-1:0];
        CfgTimeFloor:     cfg_r.time_floor   <= cfg_wdata[TimeW-1:0];
        CfgTimeCeiling:   cfg_r.time_ceiling <= cfg_wdata[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.mode   <= MODE_SEARCH;
      st_r.dir    <= DIR_NONE;
      st_r.gain   <= StartGain;
      st_r.time_c <= StartTime;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func <= in_func;
      item_r.vis  <= in_vis;
      item_r.ir   <= in_ir;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  lsagr_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign out_valid     = out_valid_r;
  assign out_gain_code = res_r.gain_code;
  assign out_time_code = res_r.time_code;
  assign out_done_res  = res_r.done_res;
  assign out_vis_out   = res_r.vis_out;
  assign out_ir_out    = res_r.ir_out;

  `LSAGR_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_r)
  `LSAGR_ASSERT_NEXT(a_restart_result, fire && item_r.func == FuncRestart,
    out_gain_code == StartGain && out_time_code == StartTime && !out_done_res)
  `LSAGR_ASSERT_NEXT(a_done_sticky, fire && item_r.func == FuncMeasure && st_r.mode == MODE_DONE,
    out_done_res && st_r.mode == MODE_DONE)
  `LSAGR_ASSERT_NOW(a_counts_zero_busy, out_valid_r && !out_done_res,
    out_vis_out == CountZero && out_ir_out == CountZero)
  `LSAGR_ASSERT_NEXT(a_stall_holds_item, in_stall, in_valid_r && $stable(item_r))

endmodule

### design/lsagr_step.sv
// Ranging decision logic: next gain/time settings and done flag for one item.
module lsagr_step (
  input  lsagr_pkg::cfg_t   cfg,
  input  lsagr_pkg::state_t st,
  input  lsagr_pkg::item_t  item,
  output lsagr_pkg::state_t st_nxt,
  output lsagr_pkg::res_t   res
);
  import lsagr_pkg::*;

  logic             up_ok;
  logic             dn_ok;
  logic [GainW-1:0] up_gain;
  logic [TimeW-1:0] up_time;
  logic [GainW-1:0] dn_gain;
  logic [TimeW-1:0] dn_time;
  logic             done;

  // one step up: gain first, then time
  always_comb begin
    up_gain = st.gain;
    up_time = st.time_c;
    up_ok   = 1'b0;
    if (st.gain < cfg.gain_ceiling) begin
      up_gain = st.gain + GainW'(1);
      up_ok   = 1'b1;
    end else if (st.time_c < cfg.time_ceiling) begin
      up_time = st.time_c + TimeW'(1);
      up_ok   = 1'b1;
    end
  end

  // one step down: gain first, then time
  always_comb begin
    dn_gain = st.gain;
    dn_time = st.time_c;
    dn_ok   = 1'b0;
    if (st.gain > cfg.gain_floor) begin
      dn_gain = st.gain - GainW'(1);
      dn_ok   = 1'b1;
    end else if (st.time_c > cfg.time_floor) begin
      dn_time = st.time_c - TimeW'(1);
      dn_ok   = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    if (item.func == FuncRestart) begin
      st_nxt.mode   = MODE_SEARCH;
      st_nxt.dir    = DIR_NONE;
      st_nxt.gain   = StartGain;
      st_nxt.time_c = StartTime;
    end else begin
      case (st.mode)
        MODE_DONE: begin
          done = 1'b1;
        end
        MODE_REC_UP: begin
          if ((st.gain == cfg.gain_ceiling && st.time_c == cfg.time_ceiling) ||
              item.vis != CountZero) begin
            done = 1'b1;
          end else begin
            st_nxt.gain   = up_gain;
            st_nxt.time_c = up_time;
          end
        end
        MODE_REC_DOWN: begin
          if ((st.gain == cfg.gain_floor && st.time_c == cfg.time_floor) ||
              item.vis != CountFull) begin
            done = 1'b1;
          end else begin
            st_nxt.gain   = dn_gain;
            st_nxt.time_c = dn_time;
          end
        end
        default: begin
          if (item.vis < cfg.low) begin
            if (st.dir == DIR_DOWN) begin
              if (item.vis != CountZero) begin
                done = 1'b1;
              end else begin
                st_nxt.gain   = up_gain;
                st_nxt.time_c = up_time;
                st_nxt.mode   = MODE_REC_UP;
              end
            end else begin
              st_nxt.dir = DIR_UP;
              if (!up_ok) begin
                done = 1'b1;
              end else begin
                st_nxt.gain   = up_gain;
                st_nxt.time_c = up_time;
              end
            end
          end else if (item.vis > cfg.high) begin
            if (st.dir == DIR_UP) begin
              if (item.vis != CountFull) begin
                done = 1'b1;
              end else begin
                st_nxt.gain   = dn_gain;
                st_nxt.time_c = dn_time;
                st_nxt.mode   = MODE_REC_DOWN;
              end
            end else begin
              st_nxt.dir = DIR_DOWN;
              if (!dn_ok) begin
                done = 1'b1;
              end else begin
                st_nxt.gain   = dn_gain;
                st_nxt.time_c = dn_time;
              end
            end
          end else begin
            done = 1'b1;
          end
        end
      endcase
      if (done) begin
        st_nxt.mode = MODE_DONE;
      end
    end
  end

  always_comb begin
    res.gain_code = st_nxt.gain;
    res.time_code = st_nxt.time_c;
    res.done_res  = done;
    res.vis_out   = done ? item.vis : CountZero;
    res.ir_out    = done ? item.ir  : CountZero;
  end

endmodule
